/* src/ascs_pkg.sv */
package ascs_pkg;

    // Default memory depth in 32-bit words
    localparam int MEM_WORDS_DEF = 4096;

    // Stream payload widths (padded to whole bytes)
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 144;

    // Stack pointer value after reset and restart
    localparam logic [31:0] SP_START = 32'h007F_FFFF;

    // Request kinds
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_STEP    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // Opcodes
    localparam logic [7:0] OP_LDC  = 8'd0;
    localparam logic [7:0] OP_ADC  = 8'd1;
    localparam logic [7:0] OP_LDL  = 8'd2;
    localparam logic [7:0] OP_STL  = 8'd3;
    localparam logic [7:0] OP_LDNL = 8'd4;
    localparam logic [7:0] OP_STNL = 8'd5;
    localparam logic [7:0] OP_ADD  = 8'd6;
    localparam logic [7:0] OP_SUB  = 8'd7;
    localparam logic [7:0] OP_SHL  = 8'd8;
    localparam logic [7:0] OP_SHR  = 8'd9;
    localparam logic [7:0] OP_ADJ  = 8'd10;
    localparam logic [7:0] OP_A2SP = 8'd11;
    localparam logic [7:0] OP_SP2A = 8'd12;
    localparam logic [7:0] OP_CALL = 8'd13;
    localparam logic [7:0] OP_RET  = 8'd14;
    localparam logic [7:0] OP_BRZ  = 8'd15;
    localparam logic [7:0] OP_BRLZ = 8'd16;
    localparam logic [7:0] OP_BR   = 8'd17;
    localparam logic [7:0] OP_HALT = 8'd18;

endpackage

/* src/accumulator_stack_cpu_step_top.sv */
// Accumulator/stack CPU that executes one request per input transfer and returns
// one result transfer with A, B, SP, PC, the halt flag and the fetched opcode.
// A load request writes one memory word, a step request fetches and executes
// one instruction at PC unless halted, a restart request sets PC to 0, SP to
// 8388607 and clears the halt flag. All state lives in one single-port
// synchronous memory (one read and one write address shared, read data
// registered) plus the register file. After reset the block sweeps the memory
// to zero, one word a cycle, with s_tready low. For a power-of-two depth the
// address is taken from its low bits; a step waits on the registered read data
// of the instruction fetch, and a ldl/ldnl step also on that of the dependent
// data read. For any other depth every memory address goes through a modulo
// unit (reciprocal multiply, low product subtract, then one correction and the
// sign fold, with the quotient and partial remainder registered between steps)
// for each address (one address for a load, none to two for a step). The next
// request is accepted while a finished result still waits in the output register.
module accumulator_stack_cpu_step_top #(
    parameter int MEM_WORDS = ascs_pkg::MEM_WORDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [11:0] word_addr, [43:12] word_data, [47:44] zero
    input  logic [ascs_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] req_type
    input  logic [ascs_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] acc_a, [63:32] acc_b, [95:64] stack_ptr, [127:96] prog_counter,
    // [128] halted, [136:129] fetched_opcode, [143:137] zero
    output logic [ascs_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ascs_pkg::*;

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam bit IS_POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);
    localparam logic [AW:0] MEM_M = (AW + 1)'(MEM_WORDS);
    // 2^32 mod MEM_WORDS, used to fold a negative address back into range
    localparam logic [63:0] WRAP_C64 = (64'd1 << 32) % MEM_WORDS;
    localparam logic [AW-1:0] WRAP_C = WRAP_C64[AW-1:0];
    localparam logic [AW:0] WRAP_ADD = MEM_M - {1'b0, WRAP_C};
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);
    // floor(2^32 / MEM_WORDS): the quotient estimate is low by at most one
    localparam logic [63:0] INV_C64 = (64'd1 << 32) / MEM_WORDS;
    localparam logic [31:0] INV_C = INV_C64[31:0];

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_DECODE,
        S_DATA_LD,
        S_RESULT
    } state_t;

    // What to do once a memory address is reduced
    typedef enum logic [1:0] {
        T_FETCH,
        T_LOAD,
        T_STORE
    } tgt_t;

    state_t state_reg, state_next;
    tgt_t   tgt_reg, tgt_next;

    logic [31:0]   a_reg, a_next;
    logic [31:0]   b_reg, b_next;
    logic [31:0]   sp_reg, sp_next;
    logic [31:0]   pc_reg, pc_next;
    logic          halt_reg, halt_next;
    logic [7:0]    opc_reg, opc_next;
    logic [31:0]   x_reg, x_next;        // unreduced address
    logic [31:0]   data_reg, data_next;  // pending write data
    logic [AW:0]   quo_reg, quo_next;    // low bits of the quotient estimate
    logic [AW:0]   rem_reg, rem_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Memory port
    logic [31:0]   mem [MEM_WORDS];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] addr_next;
    logic          mem_we;
    logic [31:0]   mem_wdata;

    // Address requests
    logic          req_addr;
    logic [31:0]   req_x;
    tgt_t          req_tgt;
    logic [31:0]   req_wdata;

    // Modulo unit datapath
    logic [63:0]   prod_w;
    logic [AW:0]   qm_lo;
    logic [AW:0]   rem_est;
    logic [AW:0]   rem_step;
    logic [AW-1:0] rem_new;
    logic [AW:0]   rem_wrapped;
    logic [AW-1:0] rem_fix;

    // Instruction fields
    logic [7:0]    opc_w;
    logic [31:0]   opd_w;
    logic [31:0]   pc_inc;
    logic [4:0]    sh_w;

    // Input fields
    logic [1:0]    in_req_type;
    logic [11:0]   in_word_addr;
    logic [31:0]   in_word_data;

    assign in_req_type  = s_tuser[1:0];
    assign in_word_addr = s_tdata[11:0];
    assign in_word_data = s_tdata[43:12];

    assign opc_w  = rd_data_reg[7:0];
    assign opd_w  = {{8{rd_data_reg[31]}}, rd_data_reg[31:8]};
    assign pc_inc = pc_reg + 32'd1;
    assign sh_w   = a_reg[4:0];

    // Estimate the quotient by the reciprocal, subtract its multiple in the low
    // bits only (the partial remainder is below 2*MEM_WORDS), correct once,
    // then fold negative values
    assign prod_w      = {32'd0, x_reg} * {32'd0, INV_C};
    assign qm_lo       = quo_reg * MEM_M;
    assign rem_est     = x_reg[AW:0] - qm_lo;
    assign rem_step    = (rem_reg >= MEM_M) ? (rem_reg - MEM_M) : rem_reg;
    assign rem_new     = rem_step[AW-1:0];
    assign rem_wrapped = {1'b0, rem_new} + WRAP_ADD;

    always_comb begin
        if (!x_reg[31]) begin
            rem_fix = rem_new;
        end else if (rem_new >= WRAP_C) begin
            rem_fix = rem_new - WRAP_C;
        end else begin
            rem_fix = rem_wrapped[AW-1:0];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        tgt_next     = tgt_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        sp_next      = sp_reg;
        pc_next      = pc_reg;
        halt_next    = halt_reg;
        opc_next     = opc_reg;
        x_next       = x_reg;
        data_next    = data_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        clr_cnt_next = clr_cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        addr_next    = '0;
        mem_we       = 1'b0;
        mem_wdata    = data_reg;
        req_addr     = 1'b0;
        req_x        = '0;
        req_tgt      = T_FETCH;
        req_wdata    = '0;

        unique case (state_reg)
            S_CLEAR: begin
                addr_next    = clr_cnt_reg;
                mem_we       = 1'b1;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    opc_next   = '0;
                    state_next = S_RESULT;
                    unique case (in_req_type)
                        REQ_LOAD: begin
                            req_addr  = 1'b1;
                            req_x     = {20'd0, in_word_addr};
                            req_tgt   = T_STORE;
                            req_wdata = in_word_data;
                        end
                        REQ_STEP: begin
                            if (!halt_reg) begin
                                req_addr = 1'b1;
                                req_x    = pc_reg;
                                req_tgt  = T_FETCH;
                            end
                        end
                        REQ_RESTART: begin
                            pc_next   = '0;
                            sp_next   = SP_START;
                            halt_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOD: begin
                cnt_next = cnt_reg - 2'd1;
                if (cnt_reg == 2'd2) begin
                    quo_next = prod_w[AW+32:32];
                end else if (cnt_reg == 2'd1) begin
                    rem_next = rem_est;
                end else begin
                    addr_next = rem_fix;
                    unique case (tgt_reg)
                        T_FETCH: state_next = S_DECODE;
                        T_LOAD:  state_next = S_DATA_LD;
                        T_STORE: begin
                            mem_we     = 1'b1;
                            state_next = S_RESULT;
                        end
                        default: state_next = S_RESULT;
                    endcase
                end
            end
            S_DECODE: begin
                opc_next   = opc_w;
                state_next = S_RESULT;
                if (opc_w >= OP_HALT) begin
                    halt_next = 1'b1;
                end else begin
                    pc_next = pc_inc;
                    unique case (opc_w)
                        OP_LDC: begin
                            b_next = a_reg;
                            a_next = opd_w;
                        end
                        OP_ADC: a_next = a_reg + opd_w;
                        OP_LDL: begin
                            b_next   = a_reg;
                            req_addr = 1'b1;
                            req_x    = sp_reg + opd_w;
                            req_tgt  = T_LOAD;
                        end
                        OP_STL: begin
                            req_addr  = 1'b1;
                            req_x     = sp_reg + opd_w;
                            req_tgt   = T_STORE;
                            req_wdata = a_reg;
                            a_next    = b_reg;
                        end
                        OP_LDNL: begin
                            req_addr = 1'b1;
                            req_x    = a_reg + opd_w;
                            req_tgt  = T_LOAD;
                        end
                        OP_STNL: begin
                            req_addr  = 1'b1;
                            req_x     = a_reg + opd_w;
                            req_tgt   = T_STORE;
                            req_wdata = b_reg;
                        end
                        OP_ADD:  a_next = a_reg + b_reg;
                        OP_SUB:  a_next = b_reg - a_reg;
                        OP_SHL:  a_next = b_reg << sh_w;
                        OP_SHR:  a_next = $unsigned($signed(b_reg) >>> sh_w);
                        OP_ADJ:  sp_next = sp_reg + opd_w;
                        OP_A2SP: begin
                            sp_next = a_reg;
                            a_next  = b_reg;
                        end
                        OP_SP2A: begin
                            b_next = a_reg;
                            a_next = sp_reg;
                        end
                        OP_CALL: begin
                            b_next  = a_reg;
                            a_next  = pc_inc;
                            pc_next = pc_inc + opd_w;
                        end
                        OP_RET: begin
                            pc_next = a_reg;
                            a_next  = b_reg;
                        end
                        OP_BRZ: begin
                            if (a_reg == 32'd0) begin
                                pc_next = pc_inc + opd_w;
                            end
                        end
                        OP_BRLZ: begin
                            if (a_reg[31]) begin
                                pc_next = pc_inc + opd_w;
                            end
                        end
                        OP_BR:   pc_next = pc_inc + opd_w;
                        default: begin
                        end
                    endcase
                end
            end
            S_DATA_LD: begin
                a_next     = rd_data_reg;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, opc_reg, halt_reg, pc_reg, sp_reg, b_reg, a_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // Reduce the address now for a power-of-two depth, else start the
        // modulo unit
        if (req_addr) begin
            x_next    = req_x;
            tgt_next  = req_tgt;
            data_next = req_wdata;
            if (IS_POW2) begin
                addr_next = req_x[AW-1:0];
                mem_wdata = req_wdata;
                unique case (req_tgt)
                    T_FETCH: state_next = S_DECODE;
                    T_LOAD:  state_next = S_DATA_LD;
                    T_STORE: begin
                        mem_we     = 1'b1;
                        state_next = S_RESULT;
                    end
                    default: state_next = S_RESULT;
                endcase
            end else begin
                cnt_next   = 2'd2;
                state_next = S_MOD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            tgt_reg     <= T_FETCH;
            a_reg       <= '0;
            b_reg       <= '0;
            sp_reg      <= SP_START;
            pc_reg      <= '0;
            halt_reg    <= 1'b0;
            opc_reg     <= '0;
            cnt_reg     <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tgt_reg     <= tgt_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            sp_reg      <= sp_next;
            pc_reg      <= pc_next;
            halt_reg    <= halt_next;
            opc_reg     <= opc_next;
            cnt_reg     <= cnt_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        x_reg      <= x_next;
        data_reg   <= data_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        m_data_reg <= m_data_next;
    end

    // Main memory: one address for read and write, registered read data
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr_next] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_next];
    end

`ifndef ASSERT_OFF
    // Every accepted transfer leaves idle before the next one can be taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted transfer did not start processing");

    // A reported opcode agrees with the halt flag of the same result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg[136:129] != 8'd0)) |->
            ((m_data_reg[136:129] >= OP_HALT) == m_data_reg[128]))
        else $error("fetched opcode and halt flag disagree");

    // The modulo unit runs all its steps without leaving early
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOD && cnt_reg != 2'd0) |=> (state_reg == S_MOD))
        else $error("address reduction ended early");

    // No result is produced during the clearing sweep
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |=> !m_valid_reg)
        else $error("result produced during memory clear");
`endif

endmodule
